@@ rtl/cdte_pkg.sv @@
package cdte_pkg;

    typedef struct packed {
        logic        cmd;
        logic [15:0] year;
        logic [7:0]  month;
        logic [7:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } cdte_in_t;

    typedef struct packed {
        logic [31:0] epoch_seconds;
        logic        valid_res;
    } cdte_out_t;

    localparam int unsigned STAGES = 6;

    localparam logic        CMD_CLOCK = 1'b0;
    localparam logic        CMD_DATE  = 1'b1;

    localparam logic [31:0] EPOCH_MIN          = 32'd1577836800;
    localparam logic [17:0] DAYS_PER_ERA       = 18'd146097;
    localparam logic [19:0] CIVIL_TO_UNIX_DAYS = 20'd719468;
    localparam logic [16:0] SECS_PER_DAY       = 17'd86400;
    localparam logic [15:0] NOON_SECS          = 16'd43200;
    localparam logic [7:0]  OFFSET_MAX_Q       = 8'd104;
    localparam logic [7:0]  OFFSET_BIAS_Q      = 8'd48;
    localparam logic [7:0]  OFFSET_RESET       = 8'd48;
    localparam logic [15:0] YEAR_MIN           = 16'd2020;

    // floor(x/25) = (x * RECIP) >> SHIFT, exact over the ranges used here
    localparam logic [12:0] RECIP25_NARROW = 13'd5243;   // x < 4096, shift 17
    localparam logic [16:0] RECIP25_WIDE   = 17'd83887;  // x < 65536, shift 21

    // Length of month 1..12 (February without leap day)
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Days from March 1st to the first of shifted month mp (0 = March)
    function automatic logic [8:0] doy_base(input logic [3:0] mp);
        logic [8:0] base;
        case (mp)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd61;
            4'd3:    base = 9'd92;
            4'd4:    base = 9'd122;
            4'd5:    base = 9'd153;
            4'd6:    base = 9'd184;
            4'd7:    base = 9'd214;
            4'd8:    base = 9'd245;
            4'd9:    base = 9'd275;
            4'd10:   base = 9'd306;
            4'd11:   base = 9'd337;
            default: base = 9'd0;
        endcase
        return base;
    endfunction

endpackage

@@ rtl/civil_datetime_to_epoch.sv @@
// Converts a Gregorian date (and, in clock mode, hour, minute and the UTC
// offset register) to Unix epoch seconds. Six register stages; a word can
// enter every cycle when the output side is not stalled. Each stage holds
// its word until the next stage frees up, so bubbles are squeezed out under
// backpressure. The stages are, in order: era split -> leap/day check ->
// day-of-era -> day count -> 25x17 seconds multiply -> time-of-day add and
// range check. Invalid inputs or results outside 2020-01-01 .. 2^32-1 give
// epoch_seconds = 0, valid_res = 0. The offset register (quarter hours plus
// 48, clamped to 104) must only be written while the block is empty.
module civil_datetime_to_epoch (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cdte_pkg::cdte_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cdte_pkg::cdte_out_t m_data,
    input  logic                cfg_wr_en,
    input  logic [7:0]          cfg_wr_data
);

    typedef struct packed {
        logic        ok;
        logic        cmd;
        logic [15:0] yy;
        logic [7:0]  era;
        logic [11:0] q25;
        logic [4:0]  year_lo;
        logic [3:0]  mi;
        logic [7:0]  day;
        logic [8:0]  doy;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } st1_t;

    typedef struct packed {
        logic               ok;
        logic [7:0]         era;
        logic [8:0]         yoe;
        logic [8:0]         doy;
        logic signed [18:0] tod;
    } st2_t;

    typedef struct packed {
        logic               ok;
        logic [24:0]        era_days;
        logic [17:0]        doe;
        logic signed [18:0] tod;
    } st3_t;

    typedef struct packed {
        logic               ok;
        logic [24:0]        days;
        logic signed [18:0] tod;
    } st4_t;

    typedef struct packed {
        logic               ok;
        logic [41:0]        secs;
        logic signed [18:0] tod;
    } st5_t;

    logic [7:0]                       offset_reg;
    logic [cdte_pkg::STAGES-1:0]      vld_reg, vld_next;
    logic [cdte_pkg::STAGES:0]        adv;

    st1_t                st1_reg, st1_next;
    st2_t                st2_reg, st2_next;
    st3_t                st3_reg, st3_next;
    st4_t                st4_reg, st4_next;
    st5_t                st5_reg, st5_next;
    cdte_pkg::cdte_out_t out_reg, out_next;

    // A stage takes a new word when it is empty or its word moves on
    always_comb begin
        adv[cdte_pkg::STAGES] = m_ready;
        for (int k = cdte_pkg::STAGES - 1; k >= 0; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
        vld_next[0] = adv[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < cdte_pkg::STAGES; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign s_ready = adv[0];
    assign m_valid = vld_reg[cdte_pkg::STAGES-1];
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            offset_reg <= cdte_pkg::OFFSET_RESET;
        end else begin
            vld_reg <= vld_next;
            if (cfg_wr_en) begin
                offset_reg <= cfg_wr_data;
            end
        end
    end

    // Stage 1: range checks, March-based year, era, year/25
    always_comb begin
        logic [15:0] yy;
        logic [24:0] era_prod;
        logic [32:0] q25_prod;
        logic [3:0]  mp;
        logic        low_m;
        low_m    = s_data.month <= 8'd2;
        yy       = s_data.year - {15'd0, low_m};
        era_prod = {13'd0, yy[15:4]} * {12'd0, cdte_pkg::RECIP25_NARROW};
        q25_prod = {17'd0, s_data.year} * {16'd0, cdte_pkg::RECIP25_WIDE};
        mp       = low_m ? (s_data.month[3:0] + 4'd9) : (s_data.month[3:0] - 4'd3);

        st1_next.ok      = (s_data.year >= cdte_pkg::YEAR_MIN)
                        && (s_data.month >= 8'd1) && (s_data.month <= 8'd12)
                        && (s_data.day != 8'd0)
                        && ((s_data.cmd == cdte_pkg::CMD_DATE) || (s_data.day <= 8'd31));
        st1_next.cmd     = s_data.cmd;
        st1_next.yy      = yy;
        st1_next.era     = era_prod[24:17];
        st1_next.q25     = q25_prod[32:21];
        st1_next.year_lo = s_data.year[4:0];
        st1_next.mi      = s_data.month[3:0];
        st1_next.day     = s_data.day;
        st1_next.doy     = cdte_pkg::doy_base(mp) + {4'd0, s_data.day[4:0]} - 9'd1;
        st1_next.hour    = s_data.hour;
        st1_next.minute  = s_data.minute;
    end

    // Stage 2: leap year and month length, year of era, time of day
    always_comb begin
        logic [4:0]         r25;
        logic               leap;
        logic [4:0]         mdays;
        logic [15:0]        yoe_full;
        logic [7:0]         qc;
        logic signed [18:0] qoff;
        logic signed [18:0] clk_secs;
        // only the low bits of year - 25*q are needed, the remainder is < 25
        r25   = st1_reg.year_lo - (5'(st1_reg.q25) * 5'd25);
        leap  = (st1_reg.year_lo[1:0] == 2'd0)
             && ((r25 != 5'd0) || (st1_reg.year_lo[3:0] == 4'd0));
        mdays = (st1_reg.mi == 4'd2) ? (5'd28 + {4'd0, leap})
                                     : cdte_pkg::month_len(st1_reg.mi);
        yoe_full = st1_reg.yy - ({8'd0, st1_reg.era} * 16'd400);

        qc   = (offset_reg > cdte_pkg::OFFSET_MAX_Q) ? cdte_pkg::OFFSET_MAX_Q : offset_reg;
        qoff = $signed({11'd0, qc}) - $signed({11'd0, cdte_pkg::OFFSET_BIAS_Q});
        clk_secs = $signed({14'd0, st1_reg.hour}) * 19'sd3600
                 + $signed({13'd0, st1_reg.minute}) * 19'sd60
                 + qoff * 19'sd900;

        st2_next.ok  = st1_reg.ok
                    && ((st1_reg.cmd == cdte_pkg::CMD_CLOCK) || (st1_reg.day <= {3'd0, mdays}));
        st2_next.era = st1_reg.era;
        st2_next.yoe = yoe_full[8:0];
        st2_next.doy = st1_reg.doy;
        st2_next.tod = (st1_reg.cmd == cdte_pkg::CMD_DATE)
                     ? $signed({3'd0, cdte_pkg::NOON_SECS}) : clk_secs;
    end

    // Stage 3: day of era and era base days
    always_comb begin
        logic [1:0] c100;
        c100 = 2'((st2_reg.yoe >= 9'd100) ? 1 : 0)
             + 2'((st2_reg.yoe >= 9'd200) ? 1 : 0)
             + 2'((st2_reg.yoe >= 9'd300) ? 1 : 0);
        st3_next.ok       = st2_reg.ok;
        st3_next.era_days = {17'd0, st2_reg.era} * {7'd0, cdte_pkg::DAYS_PER_ERA};
        st3_next.doe      = {9'd0, st2_reg.yoe} * 18'd365 + {11'd0, st2_reg.yoe[8:2]}
                          - {16'd0, c100} + {9'd0, st2_reg.doy};
        st3_next.tod      = st2_reg.tod;
    end

    // Stage 4: days since 1970-01-01 (positive for any year >= 2020)
    always_comb begin
        st4_next.ok   = st3_reg.ok;
        st4_next.days = st3_reg.era_days + {7'd0, st3_reg.doe}
                      - {5'd0, cdte_pkg::CIVIL_TO_UNIX_DAYS};
        st4_next.tod  = st3_reg.tod;
    end

    // Stage 5: day count to seconds
    always_comb begin
        st5_next.ok   = st4_reg.ok;
        st5_next.secs = {17'd0, st4_reg.days} * {25'd0, cdte_pkg::SECS_PER_DAY};
        st5_next.tod  = st4_reg.tod;
    end

    // Stage 6: add time of day, range check
    always_comb begin
        logic signed [42:0] sum;
        logic               in_range;
        sum      = $signed({1'b0, st5_reg.secs}) + 43'(st5_reg.tod);
        in_range = (sum[42:32] == 11'd0) && (sum[31:0] >= cdte_pkg::EPOCH_MIN);
        out_next.valid_res     = st5_reg.ok && in_range;
        out_next.epoch_seconds = out_next.valid_res ? sum[31:0] : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            st1_reg <= st1_next;
        end
        if (adv[1]) begin
            st2_reg <= st2_next;
        end
        if (adv[2]) begin
            st3_reg <= st3_next;
        end
        if (adv[3]) begin
            st4_reg <= st4_next;
        end
        if (adv[4]) begin
            st5_reg <= st5_next;
        end
        if (adv[5]) begin
            out_reg <= out_next;
        end
    end

endmodule

@@ rtl/cdte_chk.sv @@
module cdte_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input cdte_pkg::cdte_out_t m_data
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed under stall");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res |-> m_data.epoch_seconds == 32'd0)
        else $error("invalid result carries nonzero seconds");

    a_valid_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_res |-> m_data.epoch_seconds >= cdte_pkg::EPOCH_MIN)
        else $error("valid result before 2020-01-01");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind civil_datetime_to_epoch cdte_chk u_cdte_chk (.*);
